[src/pvdt_pkg.sv]
// ----------------------------------------------------------------------------
// pvdt_pkg
// Shared types and constants of the packed virtqueue device tracker: request
// kinds, event modes, descriptor flag bits and the request/response words.
// ----------------------------------------------------------------------------
package pvdt_pkg;

  // Request kinds carried in the input tuser
  typedef enum logic [1:0] {
    REQ_CHECK_AVAIL = 2'd0,
    REQ_COMPLETE    = 2'd1,
    REQ_INTR_CHECK  = 2'd2,
    REQ_SET_NOTIFY  = 2'd3
  } req_e;

  // Event suppression modes
  localparam logic [1:0] MODE_ENABLE     = 2'd0;
  localparam logic [1:0] MODE_DISABLE    = 2'd1;
  localparam logic [1:0] MODE_DESC       = 2'd2;
  localparam logic [1:0] MODE_UNASSIGNED = 2'd3;

  // Descriptor flag bits
  localparam int unsigned FLAG_AVAIL_BIT = 7;
  localparam int unsigned FLAG_USED_BIT  = 15;
  localparam logic [15:0] USED_FLAGS_SET = 16'h8080;

  // Reset values
  localparam logic [15:0] RING_SIZE_RST      = 16'd256;
  localparam logic [15:0] DEV_EVENT_WORD_RST = 16'h8000;

  // Register map: word index taken from paddr[2]
  localparam logic REG_IDX_RING_SIZE = 1'b0;

  // Input word: last field in the lowest bits (packed MSB first)
  typedef struct packed {
    logic [1:0]  driver_event_mode;
    logic [15:0] driver_off_wrap;
    logic [15:0] consumed_count;
    logic        notify_enable;
    logic [15:0] desc_flags;
  } req_data_t;

  typedef struct packed {
    req_e      req_type;
    req_data_t data;
  } req_t;

  // Result word: last field in the lowest bits (packed MSB first)
  typedef struct packed {
    logic [1:0]  device_event_mode_out;
    logic [15:0] device_off_wrap;
    logic        interrupt_needed;
    logic [14:0] next_avail_out;
    logic [15:0] used_flags_word;
    logic [14:0] used_slot;
    logic        avail_ready;
  } rsp_t;

endpackage

[src/packed_virtqueue_device_tracker.sv]
// ----------------------------------------------------------------------------
// packed_virtqueue_device_tracker
// Device-side index engine for an in-order packed virtqueue.
// ----------------------------------------------------------------------------
// Accepts one request word per clock, limited only by the downstream tready, and
// returns one result word per request, in order. A word waits in the input
// register while the engine evaluates it against the index state, then lands in
// the result register. The user must write ring_size over the APB port only
// while the block is idle (the block itself does not enforce this); values above
// 2^RING_INDEX_BITS act as 2^RING_INDEX_BITS.
module packed_virtqueue_device_tracker #(
  parameter int unsigned RING_INDEX_BITS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] desc_flags, [16] notify_enable, [32:17] consumed_count,
  // [48:33] driver_off_wrap, [50:49] driver_event_mode, [55:51] zero
  input  logic [55:0] s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]  s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] avail_ready, [15:1] used_slot, [31:16] used_flags_word,
  // [46:32] next_avail_out, [47] interrupt_needed, [63:48] device_off_wrap,
  // [65:64] device_event_mode_out, [71:66] zero
  output logic [71:0] m_axis_tdata,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic            in_valid_q, in_valid_d;
  pvdt_pkg::req_t  in_q;
  logic            out_valid_q, out_valid_d;
  pvdt_pkg::rsp_t  out_q, rsp;
  logic            s_fire, move, out_free;
  logic [15:0]     ring_size;

  // configuration registers
  pvdt_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .ring_size_o(ring_size)
  );

  // pipeline handshake
  assign out_free      = !out_valid_q || m_axis_tready;
  assign move          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = s_fire ? 1'b1 : (move ? 1'b0 : in_valid_q);
  assign out_valid_d = move ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_q.req_type <= pvdt_pkg::req_e'(s_axis_tuser);
      in_q.data     <= pvdt_pkg::req_data_t'(s_axis_tdata[50:0]);
    end
  end

  // request logic and index state
  pvdt_engine #(
    .RING_INDEX_BITS(RING_INDEX_BITS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ring_size_i(ring_size),
    .step_i     (move),
    .req_i      (in_q),
    .rsp_o      (rsp)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (move) begin
      out_q <= rsp;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q};

  // checks
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q))
    else $error("input stalled with a free stage");

  a_flags_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.used_flags_word == 16'd0 ||
                       out_q.used_flags_word == pvdt_pkg::USED_FLAGS_SET))
    else $error("bad used flags word");

  a_mode_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.device_event_mode_out == pvdt_pkg::MODE_DISABLE ||
                       out_q.device_event_mode_out == pvdt_pkg::MODE_DESC))
    else $error("bad device event mode");

  a_notify_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move && in_q.req_type == pvdt_pkg::REQ_SET_NOTIFY && in_q.data.notify_enable)
      |=> (m_axis_tvalid && out_q.device_event_mode_out == pvdt_pkg::MODE_DESC &&
           out_q.device_off_wrap[14:0] == out_q.next_avail_out))
    else $error("notify enable did not publish the avail index");

endmodule

[src/pvdt_regs.sv]
// ----------------------------------------------------------------------------
// pvdt_regs
// APB-style configuration register file: holds ring_size.
// ----------------------------------------------------------------------------
module pvdt_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] ring_size_o
);

  logic [15:0] ring_size_q, ring_size_d;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // register write
  always_comb begin
    ring_size_d = ring_size_q;
    if (wr_en && (paddr[2] == pvdt_pkg::REG_IDX_RING_SIZE)) begin
      ring_size_d = pwdata[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_size_q <= pvdt_pkg::RING_SIZE_RST;
    end else begin
      ring_size_q <= ring_size_d;
    end
  end

  // read back
  assign prdata = (paddr[2] == pvdt_pkg::REG_IDX_RING_SIZE) ? {16'd0, ring_size_q} : 32'd0;
  assign ring_size_o = ring_size_q;

endmodule

[src/pvdt_engine.sv]
// ----------------------------------------------------------------------------
// pvdt_engine
// Index state and single-pass request logic: availability test, in-order
// completion, event-index interrupt check and device event word update.
// ----------------------------------------------------------------------------
module pvdt_engine #(
  parameter int unsigned RING_INDEX_BITS = 15
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [15:0]      ring_size_i,
  input  logic             step_i,
  input  pvdt_pkg::req_t   req_i,
  output pvdt_pkg::rsp_t   rsp_o
);

  localparam int unsigned IW = RING_INDEX_BITS;
  localparam logic [IW:0] RingLim = {1'b1, {IW{1'b0}}};

  logic [IW-1:0] avail_idx_q, avail_idx_d, used_idx_q, used_idx_d;
  logic          avail_wrap_q, avail_wrap_d, used_wrap_q, used_wrap_d;
  logic [1:0]    ev_mode_q, ev_mode_d;
  logic [15:0]   ev_word_q, ev_word_d;

  logic [IW:0]   eff_size;
  logic [IW:0]   avail_nxt, used_nxt;
  logic          avail_wraps, used_wraps;
  logic          flag_a, flag_u;
  logic [15:0]   nw, ev, lhs;
  logic          ready, intr;

  // effective ring size, clamped to the index space
  assign eff_size = (ring_size_i > 16'(RingLim)) ? RingLim : ring_size_i[IW:0];

  // index increments
  assign avail_nxt   = {1'b0, avail_idx_q} + (IW+1)'(1);
  assign used_nxt    = {1'b0, used_idx_q} + (IW+1)'(1);
  assign avail_wraps = (avail_nxt >= eff_size);
  assign used_wraps  = (used_nxt >= eff_size);

  // availability test
  assign flag_a = req_i.data.desc_flags[pvdt_pkg::FLAG_AVAIL_BIT];
  assign flag_u = req_i.data.desc_flags[pvdt_pkg::FLAG_USED_BIT];
  assign ready  = (flag_a != flag_u) && (flag_a == avail_wrap_q);

  // event-index check, mod 2^16; used - old_used reduces to consumed_count
  assign nw  = 16'(used_idx_q);
  assign ev  = {1'b0, req_i.data.driver_off_wrap[14:0]}
             - ((req_i.data.driver_off_wrap[15] != used_wrap_q) ? 16'(eff_size) : 16'd0);
  assign lhs = nw - ev - 16'd1;

  always_comb begin
    if (req_i.data.driver_event_mode != pvdt_pkg::MODE_DESC) begin
      intr = (req_i.data.driver_event_mode == pvdt_pkg::MODE_ENABLE);
    end else begin
      intr = (lhs < req_i.data.consumed_count);
    end
  end

  // next state and result
  always_comb begin
    avail_idx_d  = avail_idx_q;
    avail_wrap_d = avail_wrap_q;
    used_idx_d   = used_idx_q;
    used_wrap_d  = used_wrap_q;
    ev_mode_d    = ev_mode_q;
    ev_word_d    = ev_word_q;
    rsp_o        = '0;
    unique case (req_i.req_type)
      pvdt_pkg::REQ_CHECK_AVAIL: begin
        rsp_o.avail_ready = ready;
      end
      pvdt_pkg::REQ_COMPLETE: begin
        rsp_o.used_slot       = 15'(used_idx_q);
        rsp_o.used_flags_word = used_wrap_q ? pvdt_pkg::USED_FLAGS_SET : 16'd0;
        avail_idx_d  = avail_wraps ? '0 : avail_nxt[IW-1:0];
        avail_wrap_d = avail_wrap_q ^ avail_wraps;
        used_idx_d   = used_wraps ? '0 : used_nxt[IW-1:0];
        used_wrap_d  = used_wrap_q ^ used_wraps;
      end
      pvdt_pkg::REQ_INTR_CHECK: begin
        rsp_o.interrupt_needed = intr;
      end
      pvdt_pkg::REQ_SET_NOTIFY: begin
        if (!req_i.data.notify_enable) begin
          ev_mode_d = pvdt_pkg::MODE_DISABLE;
        end else begin
          ev_word_d = {avail_wrap_q, 15'(avail_idx_q)};
          ev_mode_d = pvdt_pkg::MODE_DESC;
        end
      end
      default: begin
      end
    endcase
    rsp_o.next_avail_out        = 15'(avail_idx_d);
    rsp_o.device_off_wrap       = ev_word_d;
    rsp_o.device_event_mode_out = ev_mode_d;
  end

  // state registers, updated when a word moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avail_idx_q  <= '0;
      avail_wrap_q <= 1'b1;
      used_idx_q   <= '0;
      used_wrap_q  <= 1'b1;
      ev_mode_q    <= pvdt_pkg::MODE_DESC;
      ev_word_q    <= pvdt_pkg::DEV_EVENT_WORD_RST;
    end else if (step_i) begin
      avail_idx_q  <= avail_idx_d;
      avail_wrap_q <= avail_wrap_d;
      used_idx_q   <= used_idx_d;
      used_wrap_q  <= used_wrap_d;
      ev_mode_q    <= ev_mode_d;
      ev_word_q    <= ev_word_d;
    end
  end

endmodule
